// ===== design/qrs_pkg.sv =====
// shared constants and types for the quadratic root solver
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;
    // q16.16 result from q8.8 operands: n * 2^15 / a
    localparam int FRAC_SHIFT = 15;

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_INVALID  = 2'd3
    } t_root_kind;

endpackage

// ===== design/qrs_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module qrs_isqrt #(
    parameter int XW  = 34,
    parameter int SBW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [XW-1:0]       i_x,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_valid,
    output logic [XW/2-1:0]     o_root,
    output logic [SBW-1:0]      o_sb
);

    localparam int RW = XW / 2;
    localparam int MW = RW + 2;

    logic          r_vld  [RW];
    logic [XW-1:0] r_x    [RW];
    logic [MW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SBW-1:0] r_sb  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic           vld_in;
        logic [XW-1:0]  x_in;
        logic [MW-1:0]  rem_in;
        logic [RW-1:0]  root_in;
        logic [SBW-1:0] sb_in;
        logic [MW-1:0]  cand;
        logic [MW-1:0]  trial;
        logic [MW-1:0]  n_rem;
        logic [RW-1:0]  n_root;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        always_comb begin
            cand  = {rem_in[MW-3:0], x_in[XW-1 -: 2]};
            trial = {root_in, 2'b01};
            if (cand >= trial) begin
                n_rem  = cand - trial;
                n_root = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem  = cand;
                n_root = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= x_in << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_sb[k]   <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_sb    = r_sb[RW-1];

endmodule

// ===== design/qrs_div.sv =====
// two-lane pipelined signed divider with shared divisor and q16.16 saturation
module qrs_div #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int SBW        = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COEF_WIDTH+2:0]  i_num_p,
    input  logic signed [COEF_WIDTH+2:0]  i_num_m,
    input  logic signed [COEF_WIDTH-1:0]  i_den,
    input  logic [SBW-1:0]                i_sb,
    output logic                          o_valid,
    output logic [qrs_pkg::ROOT_WIDTH-1:0] o_q_p,
    output logic [qrs_pkg::ROOT_WIDTH-1:0] o_q_m,
    output logic                          o_sat,
    output logic [SBW-1:0]                o_sb
);

    localparam int W    = COEF_WIDTH;
    localparam int NW   = W + 2;
    localparam int QW   = NW + qrs_pkg::FRAC_SHIFT;
    localparam int OW   = qrs_pkg::ROOT_WIDTH;
    localparam int LW   = (QW > OW + 1) ? QW : OW + 1;
    localparam int TW   = SBW + 2;

    // prep stage: magnitudes and result signs
    logic          r_pv;
    logic [QW-1:0] r_pnum_p;
    logic [QW-1:0] r_pnum_m;
    logic [W-1:0]  r_pden;
    logic [TW-1:0] r_ptag;
    logic [W+2:0]  n_abs_p;
    logic [W+2:0]  n_abs_m;
    logic [W-1:0]  n_abs_d;

    always_comb begin
        n_abs_p = i_num_p[W+2] ? -i_num_p : i_num_p;
        n_abs_m = i_num_m[W+2] ? -i_num_m : i_num_m;
        n_abs_d = i_den[W-1] ? -i_den : i_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pnum_p <= {n_abs_p[NW-1:0], {qrs_pkg::FRAC_SHIFT{1'b0}}};
            r_pnum_m <= {n_abs_m[NW-1:0], {qrs_pkg::FRAC_SHIFT{1'b0}}};
            r_pden   <= n_abs_d;
            r_ptag   <= {i_sb, i_num_p[W+2] ^ i_den[W-1], i_num_m[W+2] ^ i_den[W-1]};
        end
    end

    logic          r_vld   [QW];
    logic [QW-1:0] r_num_p [QW];
    logic [QW-1:0] r_num_m [QW];
    logic [W-1:0]  r_rem_p [QW];
    logic [W-1:0]  r_rem_m [QW];
    logic [QW-1:0] r_quo_p [QW];
    logic [QW-1:0] r_quo_m [QW];
    logic [W-1:0]  r_den   [QW];
    logic [TW-1:0] r_tag   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          vld_in;
        logic [QW-1:0] num_p_in;
        logic [QW-1:0] num_m_in;
        logic [W-1:0]  rem_p_in;
        logic [W-1:0]  rem_m_in;
        logic [QW-1:0] quo_p_in;
        logic [QW-1:0] quo_m_in;
        logic [W-1:0]  den_in;
        logic [TW-1:0] tag_in;
        logic [W:0]    cand_p;
        logic [W:0]    cand_m;
        logic [W:0]    n_diff_p;
        logic [W:0]    n_diff_m;
        logic          n_bit_p;
        logic          n_bit_m;

        if (k == 0) begin : g_first
            assign vld_in   = r_pv;
            assign num_p_in = r_pnum_p;
            assign num_m_in = r_pnum_m;
            assign rem_p_in = '0;
            assign rem_m_in = '0;
            assign quo_p_in = '0;
            assign quo_m_in = '0;
            assign den_in   = r_pden;
            assign tag_in   = r_ptag;
        end else begin : g_next
            assign vld_in   = r_vld[k-1];
            assign num_p_in = r_num_p[k-1];
            assign num_m_in = r_num_m[k-1];
            assign rem_p_in = r_rem_p[k-1];
            assign rem_m_in = r_rem_m[k-1];
            assign quo_p_in = r_quo_p[k-1];
            assign quo_m_in = r_quo_m[k-1];
            assign den_in   = r_den[k-1];
            assign tag_in   = r_tag[k-1];
        end

        always_comb begin
            cand_p   = {rem_p_in, num_p_in[QW-1]};
            cand_m   = {rem_m_in, num_m_in[QW-1]};
            n_bit_p  = cand_p >= {1'b0, den_in};
            n_bit_m  = cand_m >= {1'b0, den_in};
            n_diff_p = n_bit_p ? cand_p - {1'b0, den_in} : cand_p;
            n_diff_m = n_bit_m ? cand_m - {1'b0, den_in} : cand_m;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num_p[k] <= num_p_in << 1;
                r_num_m[k] <= num_m_in << 1;
                r_rem_p[k] <= n_diff_p[W-1:0];
                r_rem_m[k] <= n_diff_m[W-1:0];
                r_quo_p[k] <= {quo_p_in[QW-2:0], n_bit_p};
                r_quo_m[k] <= {quo_m_in[QW-2:0], n_bit_m};
                r_den[k]   <= den_in;
                r_tag[k]   <= tag_in;
            end
        end
    end

    // sign and clamp to the q16.16 range
    logic [LW-1:0] w_mag_p;
    logic [LW-1:0] w_mag_m;
    logic          w_neg_p;
    logic          w_neg_m;
    logic          n_sat_p;
    logic          n_sat_m;
    logic [OW-1:0] n_q_p;
    logic [OW-1:0] n_q_m;
    logic          r_ov;
    logic [OW-1:0] r_q_p;
    logic [OW-1:0] r_q_m;
    logic          r_sat;
    logic [SBW-1:0] r_sb;

    localparam logic [LW-1:0] NEG_LIMIT = LW'(64'd1 << (OW - 1));
    localparam logic [LW-1:0] POS_LIMIT = LW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [OW-1:0] Q_MIN     = {1'b1, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] Q_MAX     = {1'b0, {(OW-1){1'b1}}};

    always_comb begin
        w_mag_p = LW'(r_quo_p[QW-1]);
        w_mag_m = LW'(r_quo_m[QW-1]);
        w_neg_p = r_tag[QW-1][1];
        w_neg_m = r_tag[QW-1][0];
        n_sat_p = w_neg_p ? (w_mag_p > NEG_LIMIT) : (w_mag_p > POS_LIMIT);
        n_sat_m = w_neg_m ? (w_mag_m > NEG_LIMIT) : (w_mag_m > POS_LIMIT);
        if (n_sat_p) begin
            n_q_p = w_neg_p ? Q_MIN : Q_MAX;
        end else begin
            n_q_p = w_neg_p ? -w_mag_p[OW-1:0] : w_mag_p[OW-1:0];
        end
        if (n_sat_m) begin
            n_q_m = w_neg_m ? Q_MIN : Q_MAX;
        end else begin
            n_q_m = w_neg_m ? -w_mag_m[OW-1:0] : w_mag_m[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_p <= n_q_p;
            r_q_m <= n_q_m;
            r_sat <= n_sat_p | n_sat_m;
            r_sb  <= r_tag[QW-1][TW-1:2];
        end
    end

    assign o_valid = r_ov;
    assign o_q_p   = r_q_p;
    assign o_q_m   = r_q_m;
    assign o_sat   = r_sat;
    assign o_sb    = r_sb;

endmodule

// ===== design/quadratic_root_solver.sv =====
// top level of the quadratic root solver
//
// input channel: i_valid / o_stall with coefficients i_coef_a, i_coef_b, i_coef_c
// (signed q8.8). a transfer happens when i_valid is high and o_stall is low.
// output channel: o_valid / i_stall with o_root_kind, o_root_plus, o_root_minus
// (signed q16.16) and o_saturated. a transfer happens when o_valid is high and
// i_stall is low.
// one coefficient set is accepted every cycle unless the output is stalled; each
// gives exactly one result. the pipeline registers are, in order: the products,
// the discriminant, COEF_WIDTH+1 square root stages, the numerators, the
// magnitudes, COEF_WIDTH+17 divider stages, sign and clamp, and the output
// register.
// the square root and the divider each resolve one bit per stage.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall is raised; nothing is dropped or repeated.
// reset clears all valid bits; no result is pending after reset.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_c,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_root_kind,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_root_plus,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_root_minus,
    output logic                                o_saturated
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2 * W + 2;
    localparam int RW = W + 1;
    localparam int OW = qrs_pkg::ROOT_WIDTH;
    localparam int SW = 2 + 2 * W;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // stage 1: products
    logic                  r1_v;
    logic signed [2*W-1:0] r1_bsq;
    logic signed [2*W-1:0] r1_ac;
    logic signed [W-1:0]   r1_a;
    logic signed [W-1:0]   r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bsq <= i_coef_b * i_coef_b;
            r1_ac  <= i_coef_a * i_coef_c;
            r1_a   <= i_coef_a;
            r1_b   <= i_coef_b;
        end
    end

    // stage 2: discriminant and classification
    logic signed [DW-1:0] n2_d;
    qrs_pkg::t_root_kind  n2_kind;
    logic                 r2_v;
    logic [DW-1:0]        r2_d;
    qrs_pkg::t_root_kind  r2_kind;
    logic signed [W-1:0]  r2_a;
    logic signed [W-1:0]  r2_b;

    always_comb begin
        n2_d = DW'(r1_bsq) - (DW'(r1_ac) <<< 2);
        priority if (r1_a == '0) begin
            n2_kind = qrs_pkg::KIND_INVALID;
        end else if (n2_d[DW-1]) begin
            n2_kind = qrs_pkg::KIND_COMPLEX;
        end else if (n2_d == '0) begin
            n2_kind = qrs_pkg::KIND_EQUAL;
        end else begin
            n2_kind = qrs_pkg::KIND_DISTINCT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d    <= n2_d;
            r2_kind <= n2_kind;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
        end
    end

    // square root of the discriminant
    logic          w_sq_v;
    logic [RW-1:0] w_sq_root;
    logic [SW-1:0] w_sq_sb;

    qrs_isqrt #(
        .XW  (DW),
        .SBW (SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_x     (r2_d),
        .i_sb    ({r2_kind, r2_a, r2_b}),
        .o_valid (w_sq_v),
        .o_root  (w_sq_root),
        .o_sb    (w_sq_sb)
    );

    // stage 3: numerators -b +/- sqrt(d)
    logic                r3_v;
    logic signed [W+2:0] r3_np;
    logic signed [W+2:0] r3_nm;
    logic signed [W-1:0] r3_a;
    logic [1:0]          r3_kind;
    logic signed [W+2:0] w_negb;
    logic signed [W+2:0] w_root;

    assign w_negb = -(W+3)'(signed'(w_sq_sb[W-1:0]));
    assign w_root = (W+3)'(w_sq_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_np   <= w_negb + w_root;
            r3_nm   <= w_negb - w_root;
            r3_a    <= w_sq_sb[2*W-1:W];
            r3_kind <= w_sq_sb[SW-1:SW-2];
        end
    end

    // division by a
    logic          w_dv_v;
    logic [OW-1:0] w_dv_qp;
    logic [OW-1:0] w_dv_qm;
    logic          w_dv_sat;
    logic [1:0]    w_dv_kind;

    qrs_div #(
        .COEF_WIDTH (W),
        .SBW        (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_num_p (r3_np),
        .i_num_m (r3_nm),
        .i_den   (r3_a),
        .i_sb    (r3_kind),
        .o_valid (w_dv_v),
        .o_q_p   (w_dv_qp),
        .o_q_m   (w_dv_qm),
        .o_sat   (w_dv_sat),
        .o_sb    (w_dv_kind)
    );

    // output register, roots cleared for complex or invalid input
    logic          r_ov;
    logic [1:0]    r_kind;
    logic [OW-1:0] r_rp;
    logic [OW-1:0] r_rm;
    logic          r_sat;
    logic          w_real;

    assign w_real = (w_dv_kind == qrs_pkg::KIND_DISTINCT) || (w_dv_kind == qrs_pkg::KIND_EQUAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind <= w_dv_kind;
            r_rp   <= w_real ? w_dv_qp : '0;
            r_rm   <= w_real ? w_dv_qm : '0;
            r_sat  <= w_real && w_dv_sat;
        end
    end

    assign o_valid      = r_ov;
    assign o_root_kind  = r_kind;
    assign o_root_plus  = r_rp;
    assign o_root_minus = r_rm;
    assign o_saturated  = r_sat;

endmodule

// ===== design/qrs_checker.sv =====
// port-level assertions for the quadratic root solver, with bind
module qrs_checker #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic signed [COEF_WIDTH-1:0]        i_coef_a,
    input logic signed [COEF_WIDTH-1:0]        i_coef_b,
    input logic signed [COEF_WIDTH-1:0]        i_coef_c,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [1:0]                          o_root_kind,
    input logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_root_plus,
    input logic signed [qrs_pkg::ROOT_WIDTH-1:0] o_root_minus,
    input logic                                o_saturated
);

    logic w_unused;
    assign w_unused = i_valid ^ (^i_coef_a) ^ (^i_coef_b) ^ (^i_coef_c);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_root_plus)
            && $stable(o_root_minus) && $stable(o_root_kind) && $stable(o_saturated))
        else $error("result changed under stall");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && (w_unused || !w_unused))
        else $error("input stalled without a stalled result");

    a_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_kind == qrs_pkg::KIND_COMPLEX
            || o_root_kind == qrs_pkg::KIND_INVALID)
        |-> o_root_plus == '0 && o_root_minus == '0 && !o_saturated)
        else $error("nonzero roots for complex or invalid input");

    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_EQUAL |-> o_root_plus == o_root_minus)
        else $error("equal roots differ");

endmodule

bind quadratic_root_solver qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (.*);

// ===== verif/quadratic_root_solver_test.sv =====
// self-checking testbench for the quadratic root solver
`timescale 1ns / 1ps

module quadratic_root_solver_test;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] rp;
        logic [31:0] rm;
        logic        sat;
    } t_roots;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        bit          typed;
        t_roots      res;
    } t_row;

    localparam int LIMIT = 400000;
    localparam int N_RANDOM = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [15:0] i_coef_a = '0, i_coef_b = '0, i_coef_c = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [1:0]  o_root_kind;
    logic signed [31:0] o_root_plus, o_root_minus;
    logic        o_saturated;

    t_roots expected_roots[$];
    int     errors = 0;
    int     cycles = 0;
    int     phase = 0;
    bit     src_done = 1'b0;
    bit     hold_rx = 1'b0;

    quadratic_root_solver u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] scaled_root(longint n, longint a, inout logic sat);
        longint q;
        q = (n * 32768) / a;
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            q = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
            sat = 1'b1;
            q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    function automatic t_roots solve_roots(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc);
        t_roots o;
        longint a, b, c, e, bsq;
        logic [63:0] s, sq, rt;
        logic [1:0] rem;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        c = longint'($signed(rc));
        o = '0;
        if (a == 0) begin
            o.kind = qrs_pkg::KIND_INVALID;
        end else begin
            bsq = b * b;
            e = (bsq >>> 2) - a * c;
            rem = bsq[1:0];
            if (e < 0) begin
                o.kind = qrs_pkg::KIND_COMPLEX;
            end else if (e == 0 && rem == 0) begin
                o.kind = qrs_pkg::KIND_EQUAL;
                o.rp = scaled_root(-b, a, o.sat);
                o.rm = o.rp;
            end else begin
                s = floor_sqrt(e);
                sq = s * s + s;
                if ((rem == 1) ? (sq <= e) : (sq < e)) rt = 2 * s + 1;
                else rt = 2 * s;
                o.kind = qrs_pkg::KIND_DISTINCT;
                o.rp = scaled_root(-b + longint'(rt), a, o.sat);
                o.rm = scaled_root(-b - longint'(rt), a, o.sat);
            end
        end
        return o;
    endfunction

    // directed rows; typed results only where obvious
    t_row rows[] = '{
        '{16'h0000, 16'h0100, 16'h0100, 1, '{qrs_pkg::KIND_INVALID, 0, 0, 0}},
        '{16'h0000, 16'h8000, 16'h7fff, 1, '{qrs_pkg::KIND_INVALID, 0, 0, 0}},
        '{16'h0100, 16'h0000, 16'h0100, 1, '{qrs_pkg::KIND_COMPLEX, 0, 0, 0}},
        '{16'h7fff, 16'h0000, 16'h7fff, 1, '{qrs_pkg::KIND_COMPLEX, 0, 0, 0}},
        '{16'h0100, 16'h0000, 16'h0000, 1, '{qrs_pkg::KIND_EQUAL, 0, 0, 0}},
        '{16'h0100, 16'h0000, 16'hff00, 0, '0},
        '{16'h0100, 16'hfd00, 16'h0200, 0, '0},
        '{16'h0100, 16'h0200, 16'h0100, 0, '0},
        '{16'h0001, 16'h7fff, 16'h0000, 0, '0},
        '{16'h0001, 16'h8000, 16'h0000, 0, '0},
        '{16'hffff, 16'h8000, 16'h7fff, 0, '0},
        '{16'h8000, 16'h7fff, 16'h7fff, 0, '0},
        '{16'h7fff, 16'h8000, 16'h8000, 0, '0},
        '{16'h8000, 16'h8000, 16'h8000, 0, '0},
        '{16'h7fff, 16'h7fff, 16'h8000, 0, '0},
        '{16'hffff, 16'h0001, 16'h0000, 0, '0},
        '{16'h0001, 16'h0002, 16'h0001, 0, '0},
        '{16'hff00, 16'h0300, 16'h0400, 0, '0}
    };

    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              int gap_pct, bit typed, t_roots res);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        expected_roots.push_back(typed ? res : solve_roots(a, b, c));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            3: return 16'($signed($urandom_range(2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // source
    initial begin
        logic [15:0] a, b, c;
        int gap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k])
            send_coefs(rows[k].a, rows[k].b, rows[k].c, 0, rows[k].typed, rows[k].res);
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = n * 3 / N_RANDOM;
            gap = (phase == 0) ? 29 : (phase == 1) ? 87 : 0;
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            // bias toward real equal roots: c = b^2/(4a) with b a multiple of 2a
            if ($urandom_range(9) == 0 && a != 0) begin
                a = 16'($signed($urandom_range(16)) - 8);
                if (a == 0) a = 16'd1;
                b = 16'($signed(a) * 2 * ($signed($urandom_range(8)) - 4));
                c = 16'(($signed(b) * $signed(b)) / (4 * $signed(a)));
            end
            send_coefs(a, b, c, gap, 0, '0);
        end
        i_valid <= 1'b0;
        src_done = 1'b1;
    end

    // long receiver hold-off early on, so the pipeline fills and backs up
    initial begin
        hold_rx = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin
        int pct;
        pct = (phase == 0) ? 87 : (phase == 1) ? 29 : 0;
        if (!i_rst_n || hold_rx) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_roots e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_roots.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = expected_roots.pop_front();
                if (o_root_kind !== e.kind) begin
                    $error("root_kind exp %0d got %0d", e.kind, o_root_kind);
                    errors++;
                end
                if (o_root_plus !== e.rp) begin
                    $error("root_plus exp %0d got %0d", $signed(e.rp), o_root_plus);
                    errors++;
                end
                if (o_root_minus !== e.rm) begin
                    $error("root_minus exp %0d got %0d", $signed(e.rm), o_root_minus);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (src_done && expected_roots.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_roots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qrs_pkg.sv
design/qrs_isqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
verif/quadratic_root_solver_test.sv
